// ===== rtl/odrp_pkg.sv =====
// ----------------------------------------------------------------------------
// odrp_pkg
// Shared types, register indexes and the dither pattern table of the
// ordered-dither raster packer.
// ----------------------------------------------------------------------------
package odrp_pkg;

  // Configuration register indexes and widths.
  localparam int CfgIdxW = 3;
  localparam int SizeW   = 13;

  localparam logic [CfgIdxW-1:0] RegColorMode = 3'd0;
  localparam logic [CfgIdxW-1:0] RegXPhase    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegYPhase    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRowWidth  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegImageRows = 3'd4;

  // Luma weights and the reciprocal that replaces the divide by 100.
  localparam int SumW      = 15;
  localparam int LumaR     = 30;
  localparam int LumaG     = 59;
  localparam int LumaB     = 11;
  localparam int DivMagicW = 13;
  localparam int DivMagic  = 5243;
  localparam int DivShift  = 19;
  localparam int ProdW     = SumW + DivMagicW;

  // Shade scaling: shade = luma * 26 / 256.
  localparam int ShadeCount = 26;
  localparam int ShadeW     = 5;
  localparam int ShadeProdW = 13;

  // Depth of the queue between the front and the back.
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  // Black-density patterns, darkest last; a set bit marks a black position
  // at shade (ShadeCount - 1 - index). Bit 7 is the leftmost column.
  localparam logic [7:0] DensityPat [ShadeCount][8] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00},
    '{8'h00, 8'h04, 8'h40, 8'h00, 8'h00, 8'h04, 8'h20, 8'h00},
    '{8'h00, 8'h08, 8'h41, 8'h10, 8'h00, 8'h02, 8'h20, 8'h00},
    '{8'h00, 8'h14, 8'h41, 8'h00, 8'h00, 8'h41, 8'h14, 8'h00},
    '{8'h00, 8'h14, 8'h41, 8'h08, 8'h20, 8'h82, 8'h20, 8'h08},
    '{8'h22, 8'h80, 8'h09, 8'h20, 8'h02, 8'h90, 8'h04, 8'h21},
    '{8'h24, 8'h82, 8'h10, 8'h49, 8'h00, 8'h82, 8'h10, 8'h45},
    '{8'h24, 8'h81, 8'h14, 8'h41, 8'h14, 8'h81, 8'h28, 8'h82},
    '{8'h29, 8'h80, 8'h29, 8'h82, 8'h08, 8'h22, 8'h89, 8'h54},
    '{8'h29, 8'h80, 8'h29, 8'h92, 8'h48, 8'h22, 8'h89, 8'h54},
    '{8'h29, 8'h84, 8'h29, 8'h92, 8'h48, 8'h32, 8'h89, 8'h54},
    '{8'h2A, 8'hC8, 8'h23, 8'h94, 8'h25, 8'hA8, 8'h13, 8'hC4},
    '{8'h2A, 8'hC8, 8'h23, 8'h94, 8'h67, 8'hA8, 8'h13, 8'hC4},
    '{8'h2A, 8'hCC, 8'h23, 8'h94, 8'h25, 8'hA8, 8'h13, 8'hD4},
    '{8'h35, 8'h8A, 8'h53, 8'hAA, 8'h25, 8'hCC, 8'h55, 8'hAA},
    '{8'h35, 8'hAA, 8'h53, 8'hAA, 8'h65, 8'hCC, 8'h55, 8'hAA},
    '{8'h75, 8'hAA, 8'h53, 8'hAA, 8'h65, 8'hCC, 8'h55, 8'hAB},
    '{8'h75, 8'hAA, 8'h57, 8'hAA, 8'h75, 8'hCE, 8'h55, 8'hAA},
    '{8'hB6, 8'h4B, 8'hB5, 8'hDE, 8'h65, 8'hBB, 8'hD6, 8'hAB},
    '{8'hB6, 8'h6B, 8'hB5, 8'hDE, 8'h6D, 8'hBB, 8'hD6, 8'hAB},
    '{8'hB6, 8'hEB, 8'hB5, 8'hDE, 8'h6D, 8'hBB, 8'hD6, 8'hBB},
    '{8'hB6, 8'hEB, 8'hBD, 8'hDE, 8'h6D, 8'hFB, 8'hD6, 8'hBB},
    '{8'hB6, 8'hFB, 8'hBD, 8'hDE, 8'h6F, 8'hFB, 8'hD6, 8'hBB},
    '{8'hB7, 8'hFB, 8'hBD, 8'hDE, 8'h6F, 8'hFB, 8'hD7, 8'hBB},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
  };

  // Configuration register contents.
  typedef struct packed {
    logic             color_mode;
    logic [2:0]       x_phase;
    logic [2:0]       y_phase;
    logic [SizeW-1:0] row_width;
    logic [SizeW-1:0] image_rows;
  } odrp_cfg_t;

  // Per-pixel control that travels with a pixel through the front pipeline.
  typedef struct packed {
    logic       color;
    logic [2:0] pos;
    logic       emit;
    logic       row_end;
    logic       image_end;
    logic [2:0] row_phase;
    logic [2:0] col_phase;
  } odrp_tag_t;

  // One queue entry: a mono byte in byte0, or the B, G, R bytes of a pixel.
  typedef struct packed {
    logic       color;
    logic [7:0] byte2;
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic       row_end;
    logic       image_end;
  } odrp_entry_t;

  // True when the pattern marks this position black at this shade.
  function automatic logic pattern_dark(input logic [ShadeW-1:0] shade,
                                        input logic [2:0] row_phase,
                                        input logic [2:0] col_phase);
    logic [ShadeW-1:0] idx;
    logic [7:0]        prow;
    idx  = ShadeW'(ShadeCount - 1) - shade;
    prow = DensityPat[idx][row_phase];
    return prow[~col_phase];
  endfunction

endpackage

// ===== rtl/odrp_front.sv =====
// ----------------------------------------------------------------------------
// odrp_front
// Accepts pixels, tracks the raster position, computes luma and the dither
// bit, packs mono bytes and hands finished entries to the queue.
// ----------------------------------------------------------------------------
module odrp_front #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_ROWS  = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  odrp_pkg::odrp_cfg_t cfg_i,
  input  logic               accept_i,
  input  logic [7:0]         red_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         blue_i,
  output logic [1:0]         inflight_o,
  output logic               entry_valid_o,
  output odrp_pkg::odrp_entry_t entry_o
);
  import odrp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RCW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int WW  = (CW + 1 > SizeW) ? CW + 1 : SizeW;
  localparam int HW  = (RCW + 1 > SizeW) ? RCW + 1 : SizeW;

  logic [CW-1:0]  col_q, col_d;
  logic [RCW-1:0] row_q, row_d;
  logic [WW-1:0]  w_last;
  logic [HW-1:0]  h_last;
  logic           last_col, last_row;
  logic [SumW-1:0] sum;
  odrp_tag_t      tag;

  logic            v1_q, v2_q;
  odrp_tag_t       tag1_q, tag2_q;
  logic [23:0]     rgb1_q, rgb2_q;
  logic [SumW-1:0] sum1_q;
  logic [7:0]      luma2_q;
  logic [ProdW-1:0] div_prod;

  logic [ShadeProdW-1:0] shade_prod;
  logic [ShadeW-1:0]     shade;
  logic [7:0]            acc_q, acc_d, acc_base, acc_new;
  logic                  dark;

  // Effective last column and row, with out-of-range sizes clamped.
  always_comb begin
    if (cfg_i.row_width == '0) begin
      w_last = '0;
    end else if (WW'(cfg_i.row_width) > WW'(MAX_WIDTH)) begin
      w_last = WW'(MAX_WIDTH - 1);
    end else begin
      w_last = WW'(cfg_i.row_width) - WW'(1);
    end
    if (cfg_i.image_rows == '0) begin
      h_last = '0;
    end else if (HW'(cfg_i.image_rows) > HW'(MAX_ROWS)) begin
      h_last = HW'(MAX_ROWS - 1);
    end else begin
      h_last = HW'(cfg_i.image_rows) - HW'(1);
    end
  end

  assign last_col = WW'(col_q) >= w_last;
  assign last_row = HW'(row_q) >= h_last;

  // Classify the incoming pixel.
  always_comb begin
    tag.color     = cfg_i.color_mode;
    tag.pos       = col_q[2:0];
    tag.emit      = cfg_i.color_mode || (col_q[2:0] == 3'd7) || last_col;
    tag.row_end   = last_col;
    tag.image_end = last_col && last_row;
    tag.row_phase = cfg_i.y_phase + 3'(row_q);
    tag.col_phase = cfg_i.x_phase + col_q[2:0];
  end

  assign sum = SumW'(red_i) * SumW'(LumaR) + SumW'(green_i) * SumW'(LumaG)
             + SumW'(blue_i) * SumW'(LumaB);

  // Raster position update.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + RCW'(1);
      end else begin
        col_d = col_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      v1_q  <= accept_i;
      v2_q  <= v1_q;
    end
  end

  // Stage one: weighted sum; stage two: divide by 100 via reciprocal.
  assign div_prod = ProdW'(sum1_q) * ProdW'(DivMagic);

  always_ff @(posedge clk_i) begin
    tag1_q  <= tag;
    rgb1_q  <= {red_i, green_i, blue_i};
    sum1_q  <= sum;
    tag2_q  <= tag1_q;
    rgb2_q  <= rgb1_q;
    luma2_q <= div_prod[DivShift +: 8];
  end

  // Stage three: shade, pattern bit and byte packing.
  assign shade_prod = ShadeProdW'(luma2_q) * ShadeProdW'(ShadeCount);
  assign shade      = shade_prod[8 +: ShadeW];
  assign dark       = pattern_dark(shade, tag2_q.row_phase, tag2_q.col_phase);

  always_comb begin
    acc_base = (tag2_q.pos == 3'd0) ? 8'hFF : acc_q;
    acc_new  = acc_base;
    if (dark) begin
      acc_new[~tag2_q.pos] = 1'b0;
    end
    acc_d = acc_q;
    if (v2_q) begin
      acc_d = (tag2_q.color || tag2_q.emit) ? 8'hFF : acc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 8'hFF;
    end else begin
      acc_q <= acc_d;
    end
  end

  // Entry toward the queue.
  always_comb begin
    entry_o.color     = tag2_q.color;
    entry_o.byte2     = rgb2_q[23:16];
    entry_o.byte1     = rgb2_q[15:8];
    entry_o.byte0     = tag2_q.color ? rgb2_q[7:0] : acc_new;
    entry_o.row_end   = tag2_q.row_end;
    entry_o.image_end = tag2_q.image_end;
  end

  assign entry_valid_o = v2_q && tag2_q.emit;
  assign inflight_o    = {1'b0, v1_q} + {1'b0, v2_q};

endmodule

// ===== rtl/odrp_queue.sv =====
// ----------------------------------------------------------------------------
// odrp_queue
// Short first-in first-out queue of entries between the front and the back.
// ----------------------------------------------------------------------------
module odrp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  odrp_pkg::odrp_entry_t wr_entry_i,
  input  logic                  rd_en_i,
  output odrp_pkg::odrp_entry_t head_o,
  output logic                  empty_o,
  output logic [odrp_pkg::QCntW-1:0] count_o
);
  import odrp_pkg::*;

  odrp_entry_t      slots_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      slots_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (wr_en_i) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (rd_en_i) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      count_q <= count_q + QCntW'(wr_en_i) - QCntW'(rd_en_i);
    end
  end

  assign head_o  = slots_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

// ===== rtl/odrp_back.sv =====
// ----------------------------------------------------------------------------
// odrp_back
// Expands queue entries into output bytes: one byte for a mono entry, the
// blue, green and red bytes for a color entry, held in an output register.
// ----------------------------------------------------------------------------
module odrp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  odrp_pkg::odrp_entry_t head_i,
  input  logic                  q_empty_i,
  output logic                  q_pop_o,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            data_byte_o,
  output logic                  row_end_o,
  output logic                  image_end_o,
  output logic                  run_last_o
);
  import odrp_pkg::*;

  logic       valid_q, valid_d;
  logic [1:0] beat_q, beat_d;
  logic       load, last_beat;
  logic [7:0] byte_sel;
  logic [7:0] data_q;
  logic       row_end_q, image_end_q, run_last_q;

  assign load      = !q_empty_i && (!valid_q || pop);
  assign last_beat = !head_i.color || (beat_q == 2'd2);

  // Byte of the current beat.
  always_comb begin
    case (beat_q)
      2'd1:    byte_sel = head_i.byte1;
      2'd2:    byte_sel = head_i.byte2;
      default: byte_sel = head_i.byte0;
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    beat_d  = beat_q;
    if (load) begin
      valid_d = 1'b1;
      beat_d  = last_beat ? 2'd0 : beat_q + 2'd1;
    end else if (pop && valid_q) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      beat_q  <= 2'd0;
    end else begin
      valid_q <= valid_d;
      beat_q  <= beat_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q      <= byte_sel;
      row_end_q   <= last_beat && head_i.row_end;
      image_end_q <= last_beat && head_i.image_end;
      run_last_q  <= last_beat;
    end
  end

  assign q_pop_o     = load && last_beat;
  assign empty       = !valid_q;
  assign data_byte_o = data_q;
  assign row_end_o   = row_end_q;
  assign image_end_o = image_end_q;
  assign run_last_o  = run_last_q;

endmodule

// ===== rtl/ordered_dither_raster_packer.sv =====
// ----------------------------------------------------------------------------
// ordered_dither_raster_packer
// Turns a row-ordered RGB pixel stream into BGR bytes or 8x8 ordered-dither
// monochrome bytes packed eight pixels to a byte.
//
//   Channel  | Handshake                 | Payload
//   ---------+---------------------------+-----------------------------------
//   pixel in | push / full               | red_i, green_i, blue_i
//   byte out | empty / pop               | data_byte_o, row_end_o,
//            |                           | image_end_o, run_last_o
//   config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Mono mode takes one pixel per cycle while full is low; color mode gives
// three bytes per pixel, moved one byte per cycle while pop is high.
// A pixel goes through the stage-one and stage-two registers to the queue,
// then the output register. Full is asserted from the queue fill count plus
// pixels still in the front pipeline, so the front never stalls internally.
// Reset clears the raster position, the byte being packed and the queue.
// ----------------------------------------------------------------------------
module ordered_dither_raster_packer #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_ROWS  = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [odrp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [odrp_pkg::SizeW-1:0]     cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic [7:0]                     red_i,
  input  logic [7:0]                     green_i,
  input  logic [7:0]                     blue_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [7:0]                     data_byte_o,
  output logic                           row_end_o,
  output logic                           image_end_o,
  output logic                           run_last_o
);
  import odrp_pkg::*;

  odrp_cfg_t        cfg_q;
  logic             accept;
  logic [1:0]       inflight;
  logic             entry_valid;
  odrp_entry_t      entry, head;
  logic             q_empty, q_pop;
  logic [QCntW-1:0] q_count;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.color_mode <= 1'b0;
      cfg_q.x_phase    <= 3'd0;
      cfg_q.y_phase    <= 3'd0;
      cfg_q.row_width  <= SizeW'(1);
      cfg_q.image_rows <= SizeW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegColorMode: cfg_q.color_mode <= cfg_data_i[0];
        RegXPhase:    cfg_q.x_phase    <= cfg_data_i[2:0];
        RegYPhase:    cfg_q.y_phase    <= cfg_data_i[2:0];
        RegRowWidth:  cfg_q.row_width  <= cfg_data_i;
        RegImageRows: cfg_q.image_rows <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input credit: queue entries plus pixels still in the front pipeline.
  assign full   = ({1'b0, q_count} + (QCntW + 1)'(inflight)) >= (QCntW + 1)'(QueueDepth);
  assign accept = push && !full;

  odrp_front #(
    .MAX_WIDTH(MAX_WIDTH),
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .inflight_o   (inflight),
    .entry_valid_o(entry_valid),
    .entry_o      (entry)
  );

  odrp_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (entry_valid),
    .wr_entry_i(entry),
    .rd_en_i   (q_pop),
    .head_o    (head),
    .empty_o   (q_empty),
    .count_o   (q_count)
  );

  odrp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop        (pop),
    .empty      (empty),
    .data_byte_o(data_byte_o),
    .row_end_o  (row_end_o),
    .image_end_o(image_end_o),
    .run_last_o (run_last_o)
  );

endmodule

// ===== rtl/odrp_checker.sv =====
// ----------------------------------------------------------------------------
// odrp_checker
// Port-level checks of the result stream of the raster packer.
// ----------------------------------------------------------------------------
module odrp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [7:0] data_byte_o,
  input logic       row_end_o,
  input logic       image_end_o,
  input logic       run_last_o
);

  logic [1:0] run_len_q;

  // Count results delivered since the last one that closed a pixel.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_len_q <= 2'd0;
    end else if (pop && !empty) begin
      run_len_q <= run_last_o ? 2'd0 : run_len_q + 2'd1;
    end
  end

  // A pixel never causes more than three results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && run_len_q == 2'd2) |-> run_last_o)
    else $error("more than three results for one pixel");

  // Row and raster ends fall only on the closing byte of a pixel.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && row_end_o) |-> run_last_o)
    else $error("row end on a byte that does not close its pixel");

  // The raster ends only where a row ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && image_end_o) |-> row_end_o)
    else $error("raster end without row end");

  // A waiting result stays put until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(data_byte_o) && $stable(run_last_o)))
    else $error("waiting result changed before it was taken");

endmodule

bind ordered_dither_raster_packer odrp_checker u_odrp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .data_byte_o(data_byte_o),
  .row_end_o  (row_end_o),
  .image_end_o(image_end_o),
  .run_last_o (run_last_o)
);

// ===== dv/tb_ordered_dither_raster_packer.sv =====
// ----------------------------------------------------------------------------
// tb_ordered_dither_raster_packer
// Self-checking bench for the ordered-dither raster packer. A scoreboard
// predicts every output byte from the accepted pixels and the current
// register settings. Directed rasters come first, then random phases that
// change the registers between pixel runs, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_ordered_dither_raster_packer;
  timeunit 1ns;
  timeprecision 1ps;

  import odrp_pkg::*;

  localparam int WidthMax    = 4096;
  localparam int RowsMax     = 4096;
  localparam int SettleTicks = 12;
  localparam int RandomItems = 260;
  localparam int CalmItems   = 215;

  // Black-density patterns, darkest last; bit 7 is the leftmost column.
  localparam logic [7:0] BlackPat [26][8] = '{
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h00, 8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h04, 8'h00},
    '{8'h00, 8'h04, 8'h40, 8'h00, 8'h00, 8'h04, 8'h20, 8'h00},
    '{8'h00, 8'h08, 8'h41, 8'h10, 8'h00, 8'h02, 8'h20, 8'h00},
    '{8'h00, 8'h14, 8'h41, 8'h00, 8'h00, 8'h41, 8'h14, 8'h00},
    '{8'h00, 8'h14, 8'h41, 8'h08, 8'h20, 8'h82, 8'h20, 8'h08},
    '{8'h22, 8'h80, 8'h09, 8'h20, 8'h02, 8'h90, 8'h04, 8'h21},
    '{8'h24, 8'h82, 8'h10, 8'h49, 8'h00, 8'h82, 8'h10, 8'h45},
    '{8'h24, 8'h81, 8'h14, 8'h41, 8'h14, 8'h81, 8'h28, 8'h82},
    '{8'h29, 8'h80, 8'h29, 8'h82, 8'h08, 8'h22, 8'h89, 8'h54},
    '{8'h29, 8'h80, 8'h29, 8'h92, 8'h48, 8'h22, 8'h89, 8'h54},
    '{8'h29, 8'h84, 8'h29, 8'h92, 8'h48, 8'h32, 8'h89, 8'h54},
    '{8'h2A, 8'hC8, 8'h23, 8'h94, 8'h25, 8'hA8, 8'h13, 8'hC4},
    '{8'h2A, 8'hC8, 8'h23, 8'h94, 8'h67, 8'hA8, 8'h13, 8'hC4},
    '{8'h2A, 8'hCC, 8'h23, 8'h94, 8'h25, 8'hA8, 8'h13, 8'hD4},
    '{8'h35, 8'h8A, 8'h53, 8'hAA, 8'h25, 8'hCC, 8'h55, 8'hAA},
    '{8'h35, 8'hAA, 8'h53, 8'hAA, 8'h65, 8'hCC, 8'h55, 8'hAA},
    '{8'h75, 8'hAA, 8'h53, 8'hAA, 8'h65, 8'hCC, 8'h55, 8'hAB},
    '{8'h75, 8'hAA, 8'h57, 8'hAA, 8'h75, 8'hCE, 8'h55, 8'hAA},
    '{8'hB6, 8'h4B, 8'hB5, 8'hDE, 8'h65, 8'hBB, 8'hD6, 8'hAB},
    '{8'hB6, 8'h6B, 8'hB5, 8'hDE, 8'h6D, 8'hBB, 8'hD6, 8'hAB},
    '{8'hB6, 8'hEB, 8'hB5, 8'hDE, 8'h6D, 8'hBB, 8'hD6, 8'hBB},
    '{8'hB6, 8'hEB, 8'hBD, 8'hDE, 8'h6D, 8'hFB, 8'hD6, 8'hBB},
    '{8'hB6, 8'hFB, 8'hBD, 8'hDE, 8'h6F, 8'hFB, 8'hD6, 8'hBB},
    '{8'hB7, 8'hFB, 8'hBD, 8'hDE, 8'h6F, 8'hFB, 8'hD7, 8'hBB},
    '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}
  };

  // One expected output byte.
  typedef struct {
    logic [7:0] data;
    logic       row_end;
    logic       image_end;
    logic       run_last;
  } out_byte_t;

  // Predicts the byte stream and checks the bytes that the block delivers.
  class raster_byte_board;
    logic             color;
    logic [2:0]       x_ph;
    logic [2:0]       y_ph;
    logic [SizeW-1:0] width_reg;
    logic [SizeW-1:0] rows_reg;
    logic [11:0]      col;
    logic [11:0]      row;
    logic [7:0]       acc;
    out_byte_t        due_bytes[$];
    int               errors;

    function new();
      color     = 1'b0;
      x_ph      = 3'd0;
      y_ph      = 3'd0;
      width_reg = SizeW'(1);
      rows_reg  = SizeW'(1);
      col       = '0;
      row       = '0;
      acc       = 8'hFF;
      errors    = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [SizeW-1:0] val);
      case (idx)
        RegColorMode: color     = val[0];
        RegXPhase:    x_ph      = val[2:0];
        RegYPhase:    y_ph      = val[2:0];
        RegRowWidth:  width_reg = val;
        RegImageRows: rows_reg  = val;
        default: ;
      endcase
    endfunction

    // A size of zero acts as one; sizes above the maximum act as the maximum.
    function int clamp_size(int v, int lim);
      if (v == 0) return 1;
      return (v > lim) ? lim : v;
    endfunction

    function void add_byte(logic [7:0] d, logic re, logic ie, logic rl);
      out_byte_t e;
      e.data      = d;
      e.row_end   = re;
      e.image_end = ie;
      e.run_last  = rl;
      due_bytes.push_back(e);
    endfunction

    // Works out the bytes caused by one accepted pixel.
    function void dither_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int         w;
      int         h;
      int         luma;
      int         shade;
      logic [2:0] pos;
      logic [2:0] cph;
      logic [2:0] rph;
      logic [7:0] prow;
      logic       last_col;
      logic       last_row;
      w        = clamp_size(int'(width_reg), WidthMax);
      h        = clamp_size(int'(rows_reg), RowsMax);
      pos      = col[2:0];
      last_col = (int'(col) + 1 >= w);
      last_row = (int'(row) + 1 >= h);
      if (color) begin
        acc = 8'hFF;
        add_byte(b, 1'b0, 1'b0, 1'b0);
        add_byte(g, 1'b0, 1'b0, 1'b0);
        add_byte(r, last_col, last_col && last_row, 1'b1);
      end else begin
        luma  = (30 * int'(r) + 59 * int'(g) + 11 * int'(b)) / 100;
        if (luma > 255) luma = 255;
        shade = luma * 26 / 256;
        if (shade > 25) shade = 25;
        if (pos == 3'd0) acc = 8'hFF;
        cph  = x_ph + col[2:0];
        rph  = y_ph + row[2:0];
        prow = BlackPat[25 - shade][rph];
        if (prow[7 - cph]) acc[7 - pos] = 1'b0;
        if (pos == 3'd7 || last_col) begin
          add_byte(acc, last_col, last_col && last_row, 1'b1);
          acc = 8'hFF;
        end
      end
      // Advance the raster position.
      if (last_col) begin
        col = '0;
        row = last_row ? '0 : row + 12'd1;
      end else begin
        col = col + 12'd1;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      errors++;
    endtask

    // Compares one delivered byte with the oldest expectation.
    task check_byte(logic [7:0] d, logic re, logic ie, logic rl);
      out_byte_t e;
      if (due_bytes.size() == 0) begin
        report($sformatf("unexpected byte %02h", d));
      end else begin
        e = due_bytes.pop_front();
        if (d !== e.data)
          report($sformatf("data_byte %02h, want %02h", d, e.data));
        if (re !== e.row_end)
          report($sformatf("row_end %b, want %b", re, e.row_end));
        if (ie !== e.image_end)
          report($sformatf("image_end %b, want %b", ie, e.image_end));
        if (rl !== e.run_last)
          report($sformatf("run_last %b, want %b", rl, e.run_last));
      end
    endtask

    function int pending();
      return due_bytes.size();
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni       = 1'b0;
  logic               cfg_valid_i  = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i  = '0;
  logic [SizeW-1:0]   cfg_data_i   = '0;
  logic               push         = 1'b0;
  logic               full;
  logic [7:0]         red_i        = '0;
  logic [7:0]         green_i      = '0;
  logic [7:0]         blue_i       = '0;
  logic               empty;
  logic               pop          = 1'b0;
  logic [7:0]         data_byte_o;
  logic               row_end_o;
  logic               image_end_o;
  logic               run_last_o;

  raster_byte_board sb = new();
  bit calm  = 1'b0;
  bit gappy = 1'b0;
  int fed   = 0;
  int stall_left = 0;

  ordered_dither_raster_packer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .push        (push),
    .full        (full),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .empty       (empty),
    .pop         (pop),
    .data_byte_o (data_byte_o),
    .row_end_o   (row_end_o),
    .image_end_o (image_end_o),
    .run_last_o  (run_last_o)
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Output side: check each popped transaction, then stall in random bursts.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty)
      sb.check_byte(data_byte_o, row_end_o, image_end_o, run_last_o);
    if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left--;
    end else begin
      pop <= 1'b1;
      if (!calm && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 11);
    end
  end

  // Writes one register; valid stays high so writes can go back to back.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [SizeW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, val);
  endtask

  // Sends one pixel and waits for its transaction; may idle afterwards.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    push    <= 1'b1;
    red_i   <= r;
    green_i <= g;
    blue_i  <= b;
    do @(posedge clk_i); while (full);
    sb.dither_pixel(r, g, b);
    if (gappy && !calm && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  // Stops both input channels and waits until the block has gone idle.
  task automatic settle();
    push        <= 1'b0;
    cfg_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleTicks) @(posedge clk_i);
  endtask

  // Random pixel with a bias toward the extremes and toward gray levels.
  task automatic send_random_pixel();
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = 8'($urandom_range(0, 255));
    g = 8'($urandom_range(0, 255));
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0: begin r = 8'h00; g = 8'h00; b = 8'h00; end
      1: begin r = 8'hFF; g = 8'hFF; b = 8'hFF; end
      2: begin g = r; b = r; end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  function automatic logic [SizeW-1:0] pick_size(int common_hi);
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ($urandom_range(0, 1) == 0) ? SizeW'(4096) : SizeW'(8191);
      2:       return SizeW'($urandom_range(common_hi + 1, 4 * common_hi));
      default: return SizeW'($urandom_range(1, common_hi));
    endcase
  endfunction

  // Main sequence.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Smallest raster: every pixel is a whole image; black then white.
    write_reg(RegColorMode, SizeW'(0));
    write_reg(RegXPhase, SizeW'(0));
    write_reg(RegYPhase, SizeW'(0));
    write_reg(RegRowWidth, SizeW'(0));
    write_reg(RegImageRows, SizeW'(0));
    cfg_valid_i <= 1'b0;
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF);
    settle();

    // Color bytes over a 3x2 raster.
    write_reg(RegColorMode, SizeW'(1));
    write_reg(RegRowWidth, SizeW'(3));
    write_reg(RegImageRows, SizeW'(2));
    cfg_valid_i <= 1'b0;
    send_pixel(8'hFF, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hFF, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hFF);
    send_pixel(8'h80, 8'h40, 8'h20);
    settle();

    // Oversized raster with X phase 7 and Y phase 5; stop in the middle of a byte.
    write_reg(RegColorMode, SizeW'(0));
    write_reg(RegXPhase, SizeW'(7));
    write_reg(RegYPhase, SizeW'(5));
    write_reg(RegRowWidth, SizeW'(8191));
    write_reg(RegImageRows, SizeW'(8191));
    cfg_valid_i <= 1'b0;
    send_pixel(8'd40, 8'd40, 8'd40);
    send_pixel(8'd90, 8'd90, 8'd90);
    send_pixel(8'd140, 8'd140, 8'd140);
    send_pixel(8'd190, 8'd190, 8'd190);
    send_pixel(8'd230, 8'd230, 8'd230);
    settle();

    // Switch to color in the middle of a mono byte.
    write_reg(RegColorMode, SizeW'(1));
    cfg_valid_i <= 1'b0;
    send_pixel(8'h01, 8'h02, 8'h03);
    settle();

    // Back to mono with a narrower row: the current column already lies past
    // the new row end, so this pixel closes the row.
    write_reg(RegColorMode, SizeW'(0));
    write_reg(RegRowWidth, SizeW'(3));
    cfg_valid_i <= 1'b0;
    send_pixel(8'd10, 8'd10, 8'd10);
    send_pixel(8'd60, 8'd120, 8'd200);
    send_pixel(8'd250, 8'd5, 8'd128);
    settle();

    // Fewer rows than already done: the raster ends here, then restarts.
    write_reg(RegImageRows, SizeW'(1));
    cfg_valid_i <= 1'b0;
    send_pixel(8'd0, 8'd128, 8'd0);
    send_pixel(8'd70, 8'd70, 8'd70);
    settle();

    // Random phases: new register settings, then a run of pixels.
    while (fed < RandomItems) begin
      if ($urandom_range(0, 9) < 3)
        write_reg(RegColorMode, SizeW'($urandom_range(0, 1)));
      else if ($urandom_range(0, 1) == 0)
        write_reg(RegColorMode, SizeW'(0));
      if ($urandom_range(0, 1) == 0) write_reg(RegXPhase, SizeW'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 0) write_reg(RegYPhase, SizeW'($urandom_range(0, 7)));
      if ($urandom_range(0, 1) == 0) write_reg(RegRowWidth, pick_size(20));
      if ($urandom_range(0, 1) == 0) write_reg(RegImageRows, pick_size(4));
      cfg_valid_i <= 1'b0;
      gappy = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(8, 30)) begin
        send_random_pixel();
        fed++;
        if (fed >= CalmItems) calm = 1'b1;
      end
      settle();
    end

    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
